>>> rtl/core/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and codes of the multilevel feedback queue scheduler: event
// function codes, register indexes, reset values and the queue interface.
// ----------------------------------------------------------------------------
package mlfq_pkg;

   // fixed field widths
   localparam int TASK_W      = 6;
   localparam int FUNC_W      = 3;
   localparam int CFG_IDX_W   = 3;
   localparam int CFG_DATA_W  = 16;
   localparam int LEVELS_W    = 3;
   localparam int QREG_W      = 16;
   localparam int NUM_QREGS   = 4;
   localparam int LVL_MAX_W   = 3;

   // event function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_UNBLOCK = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_BLOCK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_EXIT    = 3'd4;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_LEVELS   = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_QUANTUM0 = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_QUANTUM1 = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_QUANTUM2 = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_QUANTUM3 = 3'd4;

   // register reset values
   localparam logic [LEVELS_W-1:0] LEVELS_RESET   = 3'd4;
   localparam logic [QREG_W-1:0]   QUANTUM0_RESET = 16'd2;
   localparam logic [QREG_W-1:0]   QUANTUM1_RESET = 16'd4;
   localparam logic [QREG_W-1:0]   QUANTUM2_RESET = 16'd8;
   localparam logic [QREG_W-1:0]   QUANTUM3_RESET = 16'd16;

   // highest level with a quantum register of its own
   localparam logic [LVL_MAX_W-1:0] QLVL_LAST = 3'd3;

   // command from the sequencer to the queue block
   typedef struct packed {
      logic                 push;
      logic [LVL_MAX_W-1:0] push_lvl;
      logic [TASK_W-1:0]    push_task;
      logic                 pick;
      logic [LVL_MAX_W-1:0] last_lvl;
   } mlfq_qcmd_type;

   // pick result from the queue block
   typedef struct packed {
      logic                 found;
      logic [LVL_MAX_W-1:0] lvl;
      logic                 fwd;
   } mlfq_qsel_type;

endpackage

>>> rtl/core/mlfq_queues.sv
// ----------------------------------------------------------------------------
// mlfq_queues
// Per-level task FIFOs in one shared RAM, with head and count registers per
// level, priority pick of the lowest non-empty level and push-to-pop bypass.
// ----------------------------------------------------------------------------
module mlfq_queues #(
   parameter int LEVELS    = 4,
   parameter int MAX_TASKS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mlfq_pkg::mlfq_qcmd_type     cmd,
   output mlfq_pkg::mlfq_qsel_type     sel,
   output logic [mlfq_pkg::TASK_W-1:0] pop_task
);
   import mlfq_pkg::*;

   localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int POS_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int DEPTH = 1 << (LVL_W + POS_W);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_TASKS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);
   localparam logic [POS_W:0]   WRAP_SUM = (POS_W+1)'(MAX_TASKS);

   logic [TASK_W-1:0] store_mem [0:DEPTH-1];
   logic [POS_W-1:0]  head_ff  [LEVELS];
   logic [POS_W-1:0]  head_in  [LEVELS];
   logic [CNT_W-1:0]  count_ff [LEVELS];
   logic [CNT_W-1:0]  count_in [LEVELS];

   logic [LVL_W-1:0]  push_lvl;
   logic [LVL_W-1:0]  last_lvl;
   logic [LVL_W-1:0]  pick_lvl;
   logic              push_ok;
   logic              pick_found;
   logic              pick_fwd;
   logic              pop;
   logic [POS_W:0]    tail_sum;
   logic [POS_W-1:0]  tail_pos;
   logic [LEVELS-1:0] avail;

   assign push_lvl = LVL_W'(cmd.push_lvl);
   assign last_lvl = LVL_W'(cmd.last_lvl);

   // push is dropped on a full level
   assign push_ok  = cmd.push && (count_ff[push_lvl] < FULL_CNT);

   // tail position, head plus count wrapped once
   assign tail_sum = {1'b0, head_ff[push_lvl]} + (POS_W+1)'(count_ff[push_lvl]);
   assign tail_pos = (tail_sum >= WRAP_SUM) ? POS_W'(tail_sum - WRAP_SUM)
                                            : POS_W'(tail_sum);

   // levels in use that hold a task, counting this cycle's push
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         avail[l] = (LVL_W'(l) <= last_lvl) &&
                    ((count_ff[l] != '0) || (push_ok && (push_lvl == LVL_W'(l))));
      end
   end

   // lowest non-empty level wins
   always_comb begin
      pick_found = 1'b0;
      pick_lvl   = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (avail[l]) begin
            pick_found = 1'b1;
            pick_lvl   = LVL_W'(l);
         end
      end
   end

   // picked level was empty before the push: the pushed task comes straight back
   assign pick_fwd = push_ok && (push_lvl == pick_lvl) && (count_ff[pick_lvl] == '0);
   assign pop      = cmd.pick && pick_found;

   assign sel.found = pick_found;
   assign sel.lvl   = LVL_MAX_W'(pick_lvl);
   assign sel.fwd   = pick_fwd;

   // head and count update per level
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         count_in[l] = count_ff[l]
                     + CNT_W'(push_ok && (push_lvl == LVL_W'(l)))
                     - CNT_W'(pop && (pick_lvl == LVL_W'(l)));
         head_in[l]  = head_ff[l];
         if (pop && (pick_lvl == LVL_W'(l))) begin
            head_in[l] = (head_ff[l] == LAST_POS) ? '0 : head_ff[l] + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= head_in[l];
            count_ff[l] <= count_in[l];
         end
      end
   end

   // task RAM, one write and one registered read
   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_mem[{push_lvl, tail_pos}] <= cmd.push_task;
      end
      if (pop) begin
         pop_task <= store_mem[{pick_lvl, head_ff[pick_lvl]}];
      end
   end

endmodule

>>> rtl/core/multilevel_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Single-CPU multilevel feedback queue scheduler: per-level task FIFOs, a
// per-task level table and the running task with its remaining quantum.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | req_func, req_task_id
//  rsp     | out       | rsp_valid/rsp_ready | rsp_run_task, rsp_is_idle
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// Load, unblock and a counting tick go from acceptance through EXEC to the
// output register; an event that picks a task also goes through PICK, the
// read of the task RAM. An unknown function is taken in IDLE and gives no result.
// Reset empties all queues and leaves the CPU idle; no clearing pass.
// A result waits in the output register; the block holds until it is taken.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler #(
   parameter int LEVELS       = 4,
   parameter int MAX_TASKS    = 64,
   parameter int QUANTUM_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mlfq_pkg::FUNC_W-1:0]     req_func,
   input  logic [mlfq_pkg::TASK_W-1:0]     req_task_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mlfq_pkg::TASK_W-1:0]     rsp_run_task,
   output logic                            rsp_is_idle,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mlfq_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [mlfq_pkg::CFG_DATA_W-1:0] csr_data
);
   import mlfq_pkg::*;

   localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int TIDX_W = $clog2(MAX_TASKS);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_PICK = 2'd2;
   localparam logic [1:0] S_HOLD = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [LEVELS_W-1:0]     levels_ff;
   logic [QREG_W-1:0]       quantum_ff [NUM_QREGS];

   logic [FUNC_W-1:0]       func_ff;
   logic [TASK_W-1:0]       tid_ff;
   logic                    tid_ok_ff;
   logic                    fwd_ff, fwd_in;

   logic [TASK_W-1:0]       run_task_ff, run_task_in;
   logic                    run_valid_ff, run_valid_in;
   logic [QUANTUM_BITS-1:0] quantum_left_ff, quantum_left_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TASK_W-1:0]       rsp_task_ff, rsp_task_in;
   logic                    rsp_idle_ff, rsp_idle_in;

   logic [LVL_W-1:0]        tlev_mem [0:MAX_TASKS-1];
   logic [LVL_W-1:0]        tlev_rdata_ff;
   logic [TIDX_W-1:0]       tlev_raddr;
   logic                    tlev_we;
   logic [TIDX_W-1:0]       tlev_waddr;
   logic [LVL_W-1:0]        tlev_wdata;

   logic                    accept;
   logic                    func_known;
   logic                    slot_free;
   logic                    finish;
   logic [LVL_W-1:0]        last_lvl;
   logic [LVL_W-1:0]        cur_lvl;
   logic [LVL_W-1:0]        up_lvl;
   logic [LVL_W-1:0]        down_lvl;
   logic [1:0]              qidx;
   logic [QUANTUM_BITS-1:0] pick_quantum;

   mlfq_qcmd_type           qcmd;
   mlfq_qsel_type           qsel;
   logic [TASK_W-1:0]       pop_task;

   mlfq_queues #(
      .LEVELS    (LEVELS),
      .MAX_TASKS (MAX_TASKS)
   ) u_queues (
      .clock    (clock),
      .reset    (reset),
      .cmd      (qcmd),
      .sel      (qsel),
      .pop_task (pop_task)
   );

   // handshakes
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign func_known = req_func inside {[FUNC_LOAD:FUNC_EXIT]};
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready  = 1'b1;

   // last level in use, register clamped to 1..LEVELS
   always_comb begin
      if (levels_ff == '0) begin
         last_lvl = '0;
      end else if ({1'b0, levels_ff} > 4'(LEVELS)) begin
         last_lvl = LVL_W'(LEVELS - 1);
      end else begin
         last_lvl = LVL_W'(levels_ff - 3'd1);
      end
   end

   // stored level clamped, then one up or one down
   assign cur_lvl  = (tlev_rdata_ff > last_lvl) ? last_lvl : tlev_rdata_ff;
   assign up_lvl   = (cur_lvl != '0) ? cur_lvl - LVL_W'(1) : cur_lvl;
   assign down_lvl = (cur_lvl < last_lvl) ? cur_lvl + LVL_W'(1) : cur_lvl;

   // quantum of the picked level, deeper levels share the last register
   assign qidx         = (qsel.lvl > QLVL_LAST) ? 2'(QLVL_LAST) : qsel.lvl[1:0];
   assign pick_quantum = QUANTUM_BITS'(quantum_ff[qidx]);

   // level table read address, taken at acceptance
   assign tlev_raddr = (req_func == FUNC_UNBLOCK) ? TIDX_W'(req_task_id)
                                                  : TIDX_W'(run_task_ff);

   // event sequencer
   always_comb begin
      state_in        = state_ff;
      fwd_in          = fwd_ff;
      run_task_in     = run_task_ff;
      run_valid_in    = run_valid_ff;
      quantum_left_in = quantum_left_ff;
      tlev_we         = 1'b0;
      tlev_waddr      = TIDX_W'(tid_ff);
      tlev_wdata      = '0;
      qcmd            = '0;
      qcmd.last_lvl   = LVL_MAX_W'(last_lvl);
      finish          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept && func_known) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (func_ff)
               FUNC_LOAD: begin
                  if (tid_ok_ff) begin
                     tlev_we        = 1'b1;
                     tlev_wdata     = '0;
                     qcmd.push      = 1'b1;
                     qcmd.push_lvl  = '0;
                     qcmd.push_task = tid_ff;
                  end
                  finish = 1'b1;
               end
               FUNC_UNBLOCK: begin
                  if (tid_ok_ff) begin
                     tlev_we        = 1'b1;
                     tlev_wdata     = up_lvl;
                     qcmd.push      = 1'b1;
                     qcmd.push_lvl  = LVL_MAX_W'(up_lvl);
                     qcmd.push_task = tid_ff;
                  end
                  finish = 1'b1;
               end
               FUNC_TICK: begin
                  if (!run_valid_ff) begin
                     qcmd.pick = 1'b1;
                  end else if (quantum_left_ff <= QUANTUM_BITS'(1)) begin
                     // quantum expired: demote, requeue, pick again
                     quantum_left_in = '0;
                     tlev_we         = 1'b1;
                     tlev_waddr      = TIDX_W'(run_task_ff);
                     tlev_wdata      = down_lvl;
                     qcmd.push       = 1'b1;
                     qcmd.push_lvl   = LVL_MAX_W'(down_lvl);
                     qcmd.push_task  = run_task_ff;
                     qcmd.pick       = 1'b1;
                  end else begin
                     quantum_left_in = quantum_left_ff - QUANTUM_BITS'(1);
                     finish          = 1'b1;
                  end
               end
               FUNC_BLOCK, FUNC_EXIT: begin
                  qcmd.pick = 1'b1;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase

            // pick outcome
            if (qcmd.pick) begin
               if (qsel.found) begin
                  quantum_left_in = pick_quantum;
                  fwd_in          = qsel.fwd;
                  state_in        = S_PICK;
               end else begin
                  run_valid_in = 1'b0;
                  finish       = 1'b1;
               end
            end
         end
         S_PICK: begin
            run_valid_in = 1'b1;
            if (!fwd_ff) begin
               run_task_in = pop_task;
            end
            finish = 1'b1;
         end
         S_HOLD: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in = slot_free ? S_IDLE : S_HOLD;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_task_in  = rsp_task_ff;
      rsp_idle_in  = rsp_idle_ff;
      if (finish && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_task_in  = run_valid_in ? run_task_in : '0;
         rsp_idle_in  = !run_valid_in;
      end else if ((state_ff == S_HOLD) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_task_in  = run_valid_ff ? run_task_ff : '0;
         rsp_idle_in  = !run_valid_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_run_task = rsp_task_ff;
   assign rsp_is_idle  = rsp_idle_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         fwd_ff          <= 1'b0;
         run_task_ff     <= '0;
         run_valid_ff    <= 1'b0;
         quantum_left_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fwd_ff          <= fwd_in;
         run_task_ff     <= run_task_in;
         run_valid_ff    <= run_valid_in;
         quantum_left_ff <= quantum_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_task_ff <= rsp_task_in;
      rsp_idle_ff <= rsp_idle_in;
      if (accept) begin
         func_ff   <= req_func;
         tid_ff    <= req_task_id;
         tid_ok_ff <= (32'(req_task_id) < 32'(MAX_TASKS));
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff     <= LEVELS_RESET;
         quantum_ff[0] <= QUANTUM0_RESET;
         quantum_ff[1] <= QUANTUM1_RESET;
         quantum_ff[2] <= QUANTUM2_RESET;
         quantum_ff[3] <= QUANTUM3_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LEVELS:   levels_ff     <= csr_data[LEVELS_W-1:0];
            REG_QUANTUM0: quantum_ff[0] <= csr_data;
            REG_QUANTUM1: quantum_ff[1] <= csr_data;
            REG_QUANTUM2: quantum_ff[2] <= csr_data;
            REG_QUANTUM3: quantum_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // per-task level RAM, read at acceptance, written during execution
   always_ff @(posedge clock) begin
      if (tlev_we) begin
         tlev_mem[tlev_waddr] <= tlev_wdata;
      end
      if (accept) begin
         tlev_rdata_ff <= tlev_mem[tlev_raddr];
      end
   end

endmodule

>>> rtl/core/mlfq_checker.sv
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks of the scheduler: result encoding, output hold, busy
// window after a transaction and result delivery of a load.
// ----------------------------------------------------------------------------
module mlfq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [mlfq_pkg::FUNC_W-1:0]     req_func,
   input logic [mlfq_pkg::TASK_W-1:0]     req_task_id,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [mlfq_pkg::TASK_W-1:0]     rsp_run_task,
   input logic                            rsp_is_idle,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [mlfq_pkg::CFG_IDX_W-1:0]  csr_index,
   input logic [mlfq_pkg::CFG_DATA_W-1:0] csr_data
);
   import mlfq_pkg::*;

   // idle result reports task zero
   a_idle_task_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_idle |-> rsp_run_task == '0)
      else $error("idle result with nonzero task");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_run_task) && $stable(rsp_is_idle))
      else $error("result changed while stalled");

   // a known event keeps the block busy for the next cycle
   a_busy_after_event: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func <= FUNC_EXIT) |=> !req_ready)
      else $error("new transaction taken while an event is in flight");

   // a load with a free output delivers its result through the EXEC state and the output register
   a_load_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_LOAD) && !rsp_valid |-> ##2 rsp_valid)
      else $error("load result late");

   // reset leaves the block ready with no result
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

   // side-band ports seen but not checked here
   logic unused_ok;
   assign unused_ok = ^{req_task_id, csr_valid, csr_ready, csr_index, csr_data};

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (.*);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multilevel feedback queue scheduler. Events are
// driven on the req channel with random gaps, results are taken on the rsp
// channel with random stalls, and every result is compared field by field with
// an in-bench scheduler model updated at each accepted transaction.
// ----------------------------------------------------------------------------
module tb;
   import mlfq_pkg::*;

   localparam int LEVELS       = 4;
   localparam int MAX_TASKS    = 64;
   localparam int QUANTUM_BITS = 16;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_TICKS    = 8;
   localparam logic [FUNC_W-1:0] FUNC_BAD_LO = FUNC_EXIT + 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_BAD_HI = {FUNC_W{1'b1}};
   localparam logic [QREG_W-1:0] QUANTUM_MAX = {QREG_W{1'b1}};
   localparam logic [QREG_W-1:0] LONG_QUANTUM = 16'd40;

   typedef struct packed {
      logic [TASK_W-1:0] run_task;
      logic              is_idle;
   } sched_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func;
   logic [TASK_W-1:0]     req_task_id;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [TASK_W-1:0]     rsp_run_task;
   logic                  rsp_is_idle;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CFG_IDX_W-1:0]  csr_index;
   logic [CFG_DATA_W-1:0] csr_data;

   multilevel_feedback_queue_scheduler #(
      .LEVELS       (LEVELS),
      .MAX_TASKS    (MAX_TASKS),
      .QUANTUM_BITS (QUANTUM_BITS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_task_id  (req_task_id),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_run_task (rsp_run_task),
      .rsp_is_idle  (rsp_is_idle),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // scheduler model state
   logic [LEVELS_W-1:0] levels_cfg;
   logic [QREG_W-1:0]   quanta [NUM_QREGS];
   logic [TASK_W-1:0]   fifo_mem [LEVELS][MAX_TASKS];
   logic [TASK_W-1:0]   fifo_rd [LEVELS];
   logic [TASK_W:0]     fifo_cnt [LEVELS];
   logic [1:0]          lvl_of_task [MAX_TASKS];
   logic [TASK_W-1:0]   cur_task;
   logic                cur_valid;
   logic [QREG_W-1:0]   q_left;

   // tasks whose level entry has been written
   bit                  loaded [MAX_TASKS];
   logic [TASK_W-1:0]   loaded_ids [$];

   sched_result_type    expected_run [$];
   int                  mismatch_count;
   bit                  idle_on;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // scheduler model
   // ---------------------------------------------------------------------
   function automatic int unsigned levels_active();
      int unsigned n;
      n = 32'(levels_cfg);
      if (n < 1) n = 1;
      if (n > LEVELS) n = LEVELS;
      return n;
   endfunction

   function automatic int unsigned clamp_lvl(int unsigned lvl);
      int unsigned last;
      last = levels_active() - 1;
      return (lvl > last) ? last : lvl;
   endfunction

   function automatic void queue_push(int unsigned lvl, logic [TASK_W-1:0] t);
      int unsigned pos;
      if (fifo_cnt[lvl] >= MAX_TASKS) return;
      pos = (fifo_rd[lvl] + fifo_cnt[lvl]) % MAX_TASKS;
      fifo_mem[lvl][pos] = t;
      fifo_cnt[lvl] = fifo_cnt[lvl] + 1'b1;
   endfunction

   function automatic void sched_pick();
      int unsigned n;
      n = levels_active();
      for (int unsigned i = 0; i < n; i++) begin
         if (fifo_cnt[i] != 0) begin
            cur_task = fifo_mem[i][fifo_rd[i]];
            fifo_rd[i] = fifo_rd[i] + 1'b1;
            fifo_cnt[i] = fifo_cnt[i] - 1'b1;
            q_left = quanta[(i > QLVL_LAST) ? QLVL_LAST : i];
            cur_valid = 1'b1;
            return;
         end
      end
      cur_valid = 1'b0;
   endfunction

   function automatic void model_reset();
      levels_cfg = LEVELS_RESET;
      quanta[0] = QUANTUM0_RESET;
      quanta[1] = QUANTUM1_RESET;
      quanta[2] = QUANTUM2_RESET;
      quanta[3] = QUANTUM3_RESET;
      for (int l = 0; l < LEVELS; l++) begin
         fifo_rd[l] = '0;
         fifo_cnt[l] = '0;
      end
      for (int t = 0; t < MAX_TASKS; t++) begin
         lvl_of_task[t] = '0;
         loaded[t] = 1'b0;
      end
      cur_task = '0;
      cur_valid = 1'b0;
      q_left = '0;
   endfunction

   function automatic void model_csr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
         REG_LEVELS:   levels_cfg = d[LEVELS_W-1:0];
         REG_QUANTUM0: quanta[0] = d;
         REG_QUANTUM1: quanta[1] = d;
         REG_QUANTUM2: quanta[2] = d;
         REG_QUANTUM3: quanta[3] = d;
         default: ;
      endcase
   endfunction

   // apply one event; queue the result it produces, if any
   function automatic void predict_event(logic [FUNC_W-1:0] f, logic [TASK_W-1:0] id);
      int unsigned lvl;
      sched_result_type r;
      case (f)
         FUNC_LOAD: begin
            lvl_of_task[id] = '0;
            if (!loaded[id]) begin
               loaded[id] = 1'b1;
               loaded_ids = {loaded_ids, id};
            end
            queue_push(0, id);
         end
         FUNC_UNBLOCK: begin
            lvl = clamp_lvl(32'(lvl_of_task[id]));
            if (lvl != 0) lvl--;
            lvl_of_task[id] = lvl[1:0];
            queue_push(lvl, id);
         end
         FUNC_TICK: begin
            if (!cur_valid) begin
               sched_pick();
            end else if (q_left <= 1) begin
               q_left = '0;
               lvl = clamp_lvl(32'(lvl_of_task[cur_task]));
               if (lvl < levels_active() - 1) lvl++;
               lvl_of_task[cur_task] = lvl[1:0];
               queue_push(lvl, cur_task);
               sched_pick();
            end else begin
               q_left = q_left - 1'b1;
            end
         end
         FUNC_BLOCK, FUNC_EXIT: sched_pick();
         default: return;
      endcase
      r.run_task = cur_valid ? cur_task : '0;
      r.is_idle  = !cur_valid;
      expected_run = {expected_run, r};
   endfunction

   function automatic bit sched_busy();
      bit b;
      b = cur_valid;
      for (int l = 0; l < LEVELS; l++)
         if (fifo_cnt[l] != 0) b = 1'b1;
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   // rsp side: ready runs and stall bursts
   initial begin
      int n;
      bit v;
      rsp_ready = 1'b0;
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 12);
            v = 1'b0;
         end else begin
            n = $urandom_range(1, 16);
            v = 1'b1;
         end
         repeat (n) begin
            @(negedge clock);
            rsp_ready = v;
         end
      end
   end

   // one event transaction on the req channel
   task automatic send_event(logic [FUNC_W-1:0] f, logic [TASK_W-1:0] id);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_func    = f;
      req_task_id = id;
      do @(posedge clock); while (!req_ready);
      predict_event(f, id);
   endtask

   // stop sending and wait until every result has come back
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_run.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = d;
      do @(posedge clock); while (!csr_ready);
      model_csr(idx, d);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_all(logic [CFG_DATA_W-1:0] lv, logic [CFG_DATA_W-1:0] q0,
                            logic [CFG_DATA_W-1:0] q1, logic [CFG_DATA_W-1:0] q2,
                            logic [CFG_DATA_W-1:0] q3);
      write_csr(REG_LEVELS, lv);
      write_csr(REG_QUANTUM0, q0);
      write_csr(REG_QUANTUM1, q1);
      write_csr(REG_QUANTUM2, q2);
      write_csr(REG_QUANTUM3, q3);
   endtask

   task automatic send_bad();
      send_event(FUNC_W'(FUNC_BAD_LO + $urandom_range(0, FUNC_BAD_HI - FUNC_BAD_LO)),
                 TASK_W'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_run.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual task %0d idle %0b",
                     $time, rsp_run_task, rsp_is_idle);
            mismatch_count++;
         end else begin
            want = expected_run.pop_front();
            if (rsp_run_task !== want.run_task) begin
               $display("%0t: run_task mismatch, expected %0d, actual %0d",
                        $time, want.run_task, rsp_run_task);
               mismatch_count++;
            end
            if (rsp_is_idle !== want.is_idle) begin
               $display("%0t: is_idle mismatch, expected %0b, actual %0b",
                        $time, want.is_idle, rsp_is_idle);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // reset settings: idle events, all functions, field extremes
   task automatic test_basic_events();
      send_event(FUNC_TICK, 6'd0);
      send_event(FUNC_BLOCK, 6'd63);
      send_event(FUNC_EXIT, 6'd0);
      send_event(FUNC_LOAD, 6'd0);
      send_event(FUNC_LOAD, 6'd63);
      send_event(FUNC_LOAD, 6'd42);
      send_event(FUNC_LOAD, 6'd21);
      send_event(FUNC_TICK, 6'd63);
      send_event(FUNC_TICK, 6'd0);
      send_event(FUNC_TICK, 6'd21);
      send_event(FUNC_UNBLOCK, 6'd0);
      send_event(FUNC_UNBLOCK, 6'd63);
      send_event(FUNC_BLOCK, 6'd0);
      send_event(FUNC_EXIT, 6'd63);
      send_bad();
      send_event(FUNC_BAD_HI, 6'd63);
      repeat (4) send_event(FUNC_TICK, 6'd0);
      send_event(FUNC_BAD_LO, 6'd0);
      repeat (3) send_event(FUNC_EXIT, 6'd0);
      settle();
   endtask

   // level count extremes, out-of-range counts, zero quantum, clamping
   task automatic test_level_config();
      write_all(16'd1, 16'd0, 16'd1, 16'd1, 16'd1);
      send_event(FUNC_LOAD, 6'd1);
      send_event(FUNC_LOAD, 6'd2);
      repeat (4) send_event(FUNC_TICK, 6'd0);
      settle();
      write_all(16'd4, 16'd1, 16'd1, 16'd1, 16'd1);
      repeat (10) send_event(FUNC_TICK, 6'd0);
      settle();
      // deeper tasks fall back to the last level in use
      write_csr(REG_LEVELS, 16'd2);
      send_event(FUNC_UNBLOCK, 6'd1);
      repeat (4) send_event(FUNC_TICK, 6'd0);
      settle();
      write_csr(REG_LEVELS, 16'd0);
      send_event(FUNC_UNBLOCK, 6'd2);
      repeat (3) send_event(FUNC_TICK, 6'd0);
      send_event(FUNC_BLOCK, 6'd0);
      settle();
      write_csr(REG_LEVELS, 16'd7);
      send_event(FUNC_UNBLOCK, 6'd1);
      repeat (6) send_event(FUNC_TICK, 6'd0);
      settle();
      write_csr(REG_LEVELS, 16'hFFF9);
      repeat (4) send_event(FUNC_EXIT, 6'd0);
      settle();
      write_all(16'd4, 16'd2, 16'd4, 16'd8, 16'd16);
      while (sched_busy()) send_event(FUNC_EXIT, 6'd0);
      settle();
   endtask

   // more pushes than a level holds
   task automatic test_fifo_full();
      repeat (MAX_TASKS + 3) send_event(FUNC_LOAD, TASK_W'($urandom));
      send_event(FUNC_UNBLOCK, loaded_ids[0]);
      while (sched_busy()) send_event(FUNC_EXIT, 6'd0);
      send_event(FUNC_TICK, 6'd0);
      settle();
   endtask

   // widest quantum held without early expiry, a mid-size one counted to expiry
   task automatic test_long_quantum();
      idle_on = 1'b0;
      write_all(16'd4, QUANTUM_MAX, QUANTUM_MAX, QUANTUM_MAX, QUANTUM_MAX);
      send_event(FUNC_LOAD, 6'd9);
      send_event(FUNC_LOAD, 6'd54);
      send_event(FUNC_TICK, 6'd0);
      repeat (LONG_TICKS) send_event(FUNC_TICK, 6'd0);
      repeat (3) send_event(FUNC_EXIT, 6'd0);
      settle();
      write_all(16'd4, LONG_QUANTUM, LONG_QUANTUM, LONG_QUANTUM, LONG_QUANTUM);
      send_event(FUNC_LOAD, 6'd9);
      send_event(FUNC_LOAD, 6'd54);
      send_event(FUNC_TICK, 6'd0);
      repeat (LONG_QUANTUM) send_event(FUNC_TICK, 6'd0);
      send_event(FUNC_TICK, 6'd0);
      repeat (3) send_event(FUNC_EXIT, 6'd0);
      settle();
      idle_on = 1'b1;
   endtask

   // well-formed traffic with a little noise
   task automatic run_random(int count);
      int r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            send_bad();
         else if (r < 25 || loaded_ids.size() == 0)
            send_event(FUNC_LOAD, TASK_W'($urandom));
         else if (r < 40)
            send_event(FUNC_UNBLOCK, loaded_ids[$urandom_range(0, loaded_ids.size() - 1)]);
         else if (r < 82)
            send_event(FUNC_TICK, TASK_W'($urandom));
         else if (r < 91)
            send_event(FUNC_BLOCK, TASK_W'($urandom));
         else
            send_event(FUNC_EXIT, TASK_W'($urandom));
      end
      settle();
   endtask

   task automatic test_random();
      write_all(16'd4, 16'd1, 16'd2, 16'd3, 16'd5);
      run_random(140);
      write_all(16'd2, 16'd3, 16'd0, 16'd9, 16'd2);
      run_random(100);
      write_all(16'd1, 16'd1, 16'd7, 16'd7, 16'd7);
      run_random(70);
      write_all(16'd0, 16'd2, 16'd1, 16'd1, 16'd1);
      run_random(70);
      write_all(16'd6, CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 6)),
                CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 6)));
      run_random(100);
      // last stretch with no idling on either side
      idle_on = 1'b0;
      write_all(16'd3, CFG_DATA_W'($urandom_range(0, 4)), CFG_DATA_W'($urandom_range(0, 4)),
                CFG_DATA_W'($urandom_range(0, 4)), CFG_DATA_W'($urandom_range(0, 4)));
      run_random(110);
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_LOAD;
      req_task_id    = '0;
      csr_valid      = 1'b0;
      csr_index      = REG_LEVELS;
      csr_data       = '0;
      mismatch_count = 0;
      idle_on        = 1'b1;
      model_reset();
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_basic_events();
      test_level_config();
      test_fifo_full();
      test_long_quantum();
      test_random();
      settle();

      if (mismatch_count == 0 && expected_run.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 500000);
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_queues.sv
rtl/core/multilevel_feedback_queue_scheduler.sv
rtl/core/mlfq_checker.sv
bench/tb.sv
